/* rtl/urm_pkg.sv */
// ============================================================================
// urm_pkg - shared types and constants for the ultrasonic ranging block
// Request/result payloads, register indexes, controller command and status.
// ============================================================================
package urm_pkg;

    // Fraction bits of the distance result
    localparam int FRAC_BITS = 4;

    // Field widths
    localparam int WIDTH_W  = 15;                    // one pulse width
    localparam int TIMER_W  = 16;                    // phase timer
    localparam int SUM_W    = WIDTH_W + 2;           // sum of up to three widths
    localparam int DVD_W    = SUM_W + FRAC_BITS;     // dividend / quotient
    localparam int UPC_W    = 7;                     // us_per_cm
    localparam int DSR_W    = UPC_W + 2;             // us_per_cm * n, n <= 3
    localparam int DIST_W   = 14;
    localparam int CNT_W    = $clog2(DVD_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_US_PER_CM = 3'd4;

    // Register reset values
    localparam logic [7:0]         RST_TRIG_LOW  = 8'd2;
    localparam logic [7:0]         RST_TRIG_HIGH = 8'd10;
    localparam logic [WIDTH_W-1:0] RST_TIMEOUT   = 15'd30000;
    localparam logic [TIMER_W-1:0] RST_GAP       = 16'd1500;
    localparam logic [UPC_W-1:0]   RST_US_PER_CM = 7'd58;

    typedef struct packed {
        logic echo_level;
        logic start_request;
    } in_req_t;

    typedef struct packed {
        logic              trig_level;
        logic              busy_res;
        logic              done_res;
        logic              distance_ok;
        logic [DIST_W-1:0] distance_q4;
    } out_res_t;

    typedef enum logic [1:0] {
        TMR_HOLD  = 2'd0,
        TMR_CLEAR = 2'd1,
        TMR_ONE   = 2'd2,
        TMR_INC   = 2'd3
    } timer_op_t;

    typedef enum logic [1:0] {
        THR_LOW  = 2'd0,
        THR_HIGH = 2'd1,
        THR_GAP  = 2'd2
    } thr_sel_t;

    typedef struct packed {
        timer_op_t timer_op;
        thr_sel_t  thr_sel;
        logic      clear_samples;
        logic      end_cycle;
        logic      end_valid;
        logic      calc_load;
        logic      div_step;
        logic      out_load;
        logic      out_trig;
        logic      out_busy;
        logic      out_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit_inc;      // timer + 1 reaches selected threshold
        logic hit_tmo;      // timer reaches echo timeout
        logic gap_zero;
        logic last_sample;
        logic div_last;
        logic out_valid;
    } dp_stat_t;

endpackage

/* rtl/urm_ctrl.sv */
// ============================================================================
// urm_ctrl - ranging sequencer and result controller
// Runs the trigger/echo phases per tick and the final distance calculation.
// ============================================================================
module urm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  urm_pkg::in_req_t  in_data,
    output logic              in_stall,
    input  logic              out_stall,
    input  urm_pkg::dp_stat_t stat,
    output urm_pkg::ctrl_cmd_t cmd
);
    import urm_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_TLOW  = 6'b000010,
        PH_THIGH = 6'b000100,
        PH_WAIT  = 6'b001000,
        PH_MEAS  = 6'b010000,
        PH_GAP   = 6'b100000
    } phase_t;

    typedef enum logic [3:0] {
        C_RUN  = 4'b0001,
        C_LOAD = 4'b0010,
        C_DIV  = 4'b0100,
        C_POST = 4'b1000
    } calc_t;

    phase_t phase_reg, phase_next;
    calc_t  calc_reg, calc_next;
    logic   accept;
    logic   finished;

    assign in_stall = (calc_reg != C_RUN) || (stat.out_valid && out_stall);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        phase_next        = phase_reg;
        calc_next         = calc_reg;
        finished          = 1'b0;
        cmd.timer_op      = TMR_HOLD;
        cmd.clear_samples = 1'b0;
        cmd.end_cycle     = 1'b0;
        cmd.end_valid     = 1'b0;
        cmd.calc_load     = 1'b0;
        cmd.div_step      = 1'b0;
        cmd.out_load      = 1'b0;
        cmd.out_trig      = 1'b0;
        cmd.out_busy      = 1'b0;
        cmd.out_done      = 1'b0;

        case (phase_reg)
            PH_TLOW:  cmd.thr_sel = THR_LOW;
            PH_THIGH: cmd.thr_sel = THR_HIGH;
            default:  cmd.thr_sel = THR_GAP;
        endcase

        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (in_data.start_request)
                    begin
                        phase_next        = PH_TLOW;
                        cmd.timer_op      = TMR_CLEAR;
                        cmd.clear_samples = 1'b1;
                    end
                end
                PH_TLOW:
                begin
                    cmd.timer_op = TMR_INC;
                    if (stat.hit_inc)
                    begin
                        phase_next   = PH_THIGH;
                        cmd.timer_op = TMR_CLEAR;
                    end
                end
                PH_THIGH:
                begin
                    cmd.timer_op = TMR_INC;
                    if (stat.hit_inc)
                    begin
                        phase_next   = PH_WAIT;
                        cmd.timer_op = TMR_CLEAR;
                    end
                end
                PH_WAIT:
                begin
                    if (in_data.echo_level)
                    begin
                        phase_next   = PH_MEAS;
                        cmd.timer_op = TMR_ONE;
                    end
                    else if (stat.hit_tmo)
                    begin
                        cmd.end_cycle = 1'b1;
                    end
                    else
                    begin
                        cmd.timer_op = TMR_INC;
                    end
                end
                PH_MEAS:
                begin
                    if (!in_data.echo_level)
                    begin
                        cmd.end_cycle = 1'b1;
                        cmd.end_valid = 1'b1;
                    end
                    else if (stat.hit_tmo)
                    begin
                        cmd.end_cycle = 1'b1;
                    end
                    else
                    begin
                        cmd.timer_op = TMR_INC;
                    end
                end
                PH_GAP:
                begin
                    cmd.timer_op = TMR_INC;
                    if (stat.hit_inc)
                    begin
                        phase_next   = PH_TLOW;
                        cmd.timer_op = TMR_CLEAR;
                    end
                end
                default:
                begin
                    phase_next   = PH_IDLE;
                    cmd.timer_op = TMR_CLEAR;
                end
            endcase

            if (cmd.end_cycle)
            begin
                cmd.timer_op = TMR_CLEAR;
                if (stat.last_sample)
                begin
                    phase_next = PH_IDLE;
                    finished   = 1'b1;
                end
                else if (stat.gap_zero)
                begin
                    phase_next = PH_TLOW;
                end
                else
                begin
                    phase_next = PH_GAP;
                end
            end

            if (finished)
            begin
                calc_next = C_LOAD;
            end
            else
            begin
                cmd.out_load = 1'b1;
                cmd.out_trig = (phase_reg == PH_THIGH);
                cmd.out_busy = (phase_next != PH_IDLE);
            end
        end

        case (calc_reg)
            C_RUN:  calc_next = calc_next;
            C_LOAD:
            begin
                cmd.calc_load = 1'b1;
                calc_next     = C_DIV;
            end
            C_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    calc_next = C_POST;
                end
            end
            C_POST:
            begin
                if (!stat.out_valid || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_done = 1'b1;
                    calc_next    = C_RUN;
                end
            end
            default: calc_next = C_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            calc_reg  <= C_RUN;
        end
        else
        begin
            phase_reg <= phase_next;
            calc_reg  <= calc_next;
        end
    end

endmodule

/* rtl/urm_dp.sv */
// ============================================================================
// urm_dp - ranging datapath
// Config registers, phase timer, samples, median/average, divider, result reg.
// ============================================================================
module urm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [urm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [urm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  urm_pkg::ctrl_cmd_t            cmd,
    output urm_pkg::dp_stat_t             stat,
    input  logic                          out_stall,
    output logic                          out_valid,
    output urm_pkg::out_res_t             out_data
);
    import urm_pkg::*;

    // configuration
    logic [7:0]         trig_low_reg, trig_high_reg;
    logic [WIDTH_W-1:0] timeout_reg;
    logic [TIMER_W-1:0] gap_reg;
    logic [UPC_W-1:0]   upc_reg;

    // sequencing
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [TIMER_W-1:0] timer_inc;
    logic [TIMER_W-1:0] thr;
    logic [1:0]         idx_reg;
    logic [2:0]         valid_reg;
    logic [WIDTH_W-1:0] width_reg [3];

    // final calculation
    logic [WIDTH_W-1:0] a, b, c, lo_ab, hi_ab, median;
    logic [1:0]         n_valid;
    logic [SUM_W-1:0]   sum_sel;
    logic [UPC_W-1:0]   upc_eff;
    logic [DSR_W-1:0]   dsr_calc;
    logic [DSR_W-1:0]   dsr_reg;
    logic [DSR_W-1:0]   rem_reg, rem_next;
    logic [DVD_W-1:0]   quo_reg, quo_next;
    logic [DSR_W:0]     rem_shift;
    logic [CNT_W-1:0]   cnt_reg;
    logic               ok;
    logic [DIST_W-1:0]  dist_sat;

    out_res_t out_reg;
    logic     out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_low_reg  <= RST_TRIG_LOW;
            trig_high_reg <= RST_TRIG_HIGH;
            timeout_reg   <= RST_TIMEOUT;
            gap_reg       <= RST_GAP;
            upc_reg       <= RST_US_PER_CM;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TRIG_LOW:  trig_low_reg  <= cfg_wdata[7:0];
                REG_TRIG_HIGH: trig_high_reg <= cfg_wdata[7:0];
                REG_TIMEOUT:   timeout_reg   <= cfg_wdata[WIDTH_W-1:0];
                REG_GAP:       gap_reg       <= cfg_wdata[TIMER_W-1:0];
                REG_US_PER_CM: upc_reg       <= cfg_wdata[UPC_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---- timer and compares ----
    assign timer_inc = timer_reg + TIMER_W'(1);

    always_comb
    begin
        case (cmd.thr_sel)
            THR_LOW:  thr = TIMER_W'(trig_low_reg);
            THR_HIGH: thr = TIMER_W'(trig_high_reg);
            default:  thr = gap_reg;
        endcase
        case (cmd.timer_op)
            TMR_CLEAR: timer_next = '0;
            TMR_ONE:   timer_next = TIMER_W'(1);
            TMR_INC:   timer_next = timer_inc;
            default:   timer_next = timer_reg;
        endcase
    end

    assign stat.hit_inc     = (timer_inc >= thr);
    assign stat.hit_tmo     = (timer_reg >= TIMER_W'(timeout_reg));
    assign stat.gap_zero    = (gap_reg == '0);
    assign stat.last_sample = (idx_reg == 2'd2);
    assign stat.div_last    = (cnt_reg == CNT_W'(DVD_W - 1));
    assign stat.out_valid   = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            timer_reg <= timer_next;
            if (cmd.clear_samples)
            begin
                idx_reg   <= '0;
                valid_reg <= '0;
            end
            else if (cmd.end_cycle)
            begin
                idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                if (cmd.end_valid)
                begin
                    valid_reg[idx_reg] <= 1'b1;
                end
            end
        end
    end

    // pulse widths: no reset, read only where the valid bit is set
    always_ff @(posedge clk)
    begin
        if (cmd.end_cycle && cmd.end_valid)
        begin
            width_reg[idx_reg] <= timer_reg[WIDTH_W-1:0];
        end
    end

    // ---- median / average operands ----
    assign a      = width_reg[0];
    assign b      = width_reg[1];
    assign c      = width_reg[2];
    assign lo_ab  = (a < b) ? a : b;
    assign hi_ab  = (a < b) ? b : a;
    assign median = (hi_ab < c) ? ((lo_ab > hi_ab) ? lo_ab : hi_ab)
                                : ((lo_ab > c) ? lo_ab : c);

    assign n_valid = 2'(valid_reg[0]) + 2'(valid_reg[1]) + 2'(valid_reg[2]);
    assign upc_eff = (upc_reg == '0) ? UPC_W'(1) : upc_reg;
    assign ok      = |valid_reg;

    always_comb
    begin
        if (valid_reg == 3'b111)
        begin
            sum_sel  = SUM_W'(median);
            dsr_calc = DSR_W'(upc_eff);
        end
        else
        begin
            sum_sel  = (valid_reg[0] ? SUM_W'(a) : '0)
                     + (valid_reg[1] ? SUM_W'(b) : '0)
                     + (valid_reg[2] ? SUM_W'(c) : '0);
            dsr_calc = DSR_W'(upc_eff) * DSR_W'(n_valid);
        end
    end

    // ---- restoring divider, one quotient bit per cycle ----
    assign rem_shift = {rem_reg, quo_reg[DVD_W-1]};

    always_comb
    begin
        if (rem_shift >= {1'b0, dsr_reg})
        begin
            rem_next = DSR_W'(rem_shift - {1'b0, dsr_reg});
            quo_next = {quo_reg[DVD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift[DSR_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.calc_load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc_load)
        begin
            dsr_reg <= dsr_calc;
            rem_reg <= '0;
            quo_reg <= DVD_W'(sum_sel) << FRAC_BITS;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign dist_sat = !ok ? '0
                    : (quo_reg > DVD_W'(DIST_MAX)) ? DIST_MAX : quo_reg[DIST_W-1:0];

    // ---- result register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.trig_level  <= cmd.out_trig;
            out_reg.busy_res    <= cmd.out_busy;
            out_reg.done_res    <= cmd.out_done;
            out_reg.distance_ok <= cmd.out_done && ok;
            out_reg.distance_q4 <= cmd.out_done ? dist_sat : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* rtl/ultrasonic_range_median3.sv */
// ============================================================================
// ultrasonic_range_median3 - ultrasonic ranging with three-sample filter
// Tick-driven trigger/echo sequencer; median or average of three echo widths.
// ============================================================================
//
//  channel  | signals                               | carries
//  ---------+---------------------------------------+---------------------------
//  request  | in_valid, in_stall, in_data           | echo level, start (1 tick)
//  result   | out_valid, out_stall, out_data        | trig, busy, done, distance
//  config   | cfg_wr_en, cfg_index, cfg_wdata       | five timing/scale registers
//
//  An ordinary tick request's result loads at the accepting edge.
//  The request ending the third measurement runs through accept, form median/sum
//  and divisor, 21 divider steps and load; the load waits out any output stall.
//  A request is taken while a result waits only if that result leaves in the
//  same cycle; in_stall stays high through the division.
//  Reset (rst_n, async) idles the sequencer and restores register defaults.
//
module ultrasonic_range_median3 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  urm_pkg::in_req_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output urm_pkg::out_res_t             out_data,
    input  logic                          cfg_wr_en,
    input  logic [urm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [urm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import urm_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequencer: phase FSM per tick plus the end-of-measurement calc FSM
    urm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: registers, timer, samples, filter, divider, result register
    urm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

`ifndef SYNTH
    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result register overwritten while stalled");

    // requests must be held off while the divider runs
    a_stall_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> in_stall)
        else $error("request accepted during division");

    // a finished measurement closes the sequence
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.done_res) |-> (!out_data.busy_res && !out_data.trig_level))
        else $error("done result shows busy or trigger");

    // error results carry no distance
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.distance_ok) |-> (out_data.distance_q4 == '0))
        else $error("distance present without a valid sample");
`endif

endmodule
